>>> sv/jpns_pkg.sv
package jpns_pkg;

    localparam int unsigned LEN_W = 8;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_LINE  = 3'd1,
        PH_BLOCK = 3'd2,
        PH_KEY   = 3'd3,
        PH_NAME  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_PKG   = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_P  = 8'h70;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    localparam logic [2:0] KEY_LAST = 3'd5;
    localparam logic [2:0] KEY_LEN  = 3'd6;

    typedef struct packed {
        phase_t            phase;
        logic              slash_seen;
        logic              comment_escaped;
        logic              comment_star;
        logic [2:0]        keyword_position;
        logic              keyword_matches;
        logic [LEN_W-1:0]  name_length;
        logic              name_truncated;
    } scan_state_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] name_char;
        logic [1:0] status;
    } scan_result_t;

    localparam scan_state_t STATE_RESET = '{
        phase:            PH_LEAD,
        slash_seen:       1'b0,
        comment_escaped:  1'b0,
        comment_star:     1'b0,
        keyword_position: 3'd0,
        keyword_matches:  1'b1,
        name_length:      '0,
        name_truncated:   1'b0
    };

    // tail of the keyword after the leading 'p'
    function automatic logic [7:0] keyword_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h61;
            3'd1:    c = 8'h63;
            3'd2:    c = 8'h6b;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h67;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
        return r;
    endfunction

endpackage

>>> sv/jpns_step.sv
module jpns_step #(
    parameter int unsigned MAX_NAME = 128
) (
    input  jpns_pkg::scan_state_t  state,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_text,
    output jpns_pkg::scan_state_t  state_next,
    output jpns_pkg::scan_result_t result
);
    import jpns_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME);

    logic [2:0] pos;
    logic [2:0] pos_next;
    logic       match_next;
    logic       is_alnum;
    logic       name_full;

    assign pos        = (state.keyword_position > KEY_LAST) ? KEY_LAST : state.keyword_position;
    assign pos_next   = pos + 3'd1;
    assign match_next = state.keyword_matches && (fold_lower(in_byte) == keyword_char(pos));
    assign is_alnum   = (in_byte >= CH_0 && in_byte <= CH_9)
                     || (in_byte >= CH_UP_A && in_byte <= CH_UP_Z)
                     || (in_byte >= CH_LOW_A && in_byte <= CH_LOW_Z);
    assign name_full  = state.name_length >= LEN_MAX;

    always_comb
    begin
        state_next = state;
        result     = '{valid: 1'b0, kind: KIND_CHAR, name_char: 8'd0, status: ST_FOUND};

        if (end_of_text)
        begin
            if (state.phase == PH_NAME)
                result = '{valid: 1'b1, kind: KIND_FINISH, name_char: 8'd0,
                           status: state.name_truncated ? ST_TRUNC : ST_FOUND};
            else if (state.phase == PH_LEAD || state.phase == PH_LINE
                     || state.phase == PH_BLOCK || state.phase == PH_KEY)
                result = '{valid: 1'b1, kind: KIND_FINISH, name_char: 8'd0,
                           status: ST_EARLY_END};
            state_next = STATE_RESET;
        end
        else
        begin
            unique case (state.phase)
                PH_LEAD:
                begin
                    priority if (in_byte == CH_SLASH)
                    begin
                        if (state.slash_seen)
                        begin
                            state_next.phase           = PH_LINE;
                            state_next.comment_escaped = 1'b0;
                            state_next.comment_star    = 1'b0;
                            state_next.slash_seen      = 1'b0;
                        end
                        else
                            state_next.slash_seen = 1'b1;
                    end
                    else if (in_byte == CH_STAR)
                    begin
                        if (state.slash_seen)
                        begin
                            state_next.phase           = PH_BLOCK;
                            state_next.comment_escaped = 1'b0;
                            state_next.comment_star    = 1'b0;
                        end
                        state_next.slash_seen = 1'b0;
                    end
                    else if (in_byte == CH_SPACE || in_byte == CH_TAB
                             || in_byte == CH_CR || in_byte == CH_LF)
                        state_next.slash_seen = 1'b0;
                    else
                    begin
                        state_next.slash_seen = 1'b0;
                        if (in_byte == CH_LOW_P)
                        begin
                            state_next.phase            = PH_KEY;
                            state_next.keyword_position = 3'd0;
                            state_next.keyword_matches  = 1'b1;
                        end
                        else
                        begin
                            result = '{valid: 1'b1, kind: KIND_FINISH, name_char: 8'd0,
                                       status: ST_NOT_PKG};
                            state_next.phase = PH_DONE;
                        end
                    end
                end
                PH_LINE, PH_BLOCK:
                begin
                    priority if (in_byte == CH_SLASH)
                    begin
                        if (!state.comment_escaped && state.comment_star)
                        begin
                            state_next.phase           = PH_LEAD;
                            state_next.comment_escaped = 1'b0;
                            state_next.comment_star    = 1'b0;
                            state_next.slash_seen      = 1'b0;
                        end
                    end
                    else if (in_byte == CH_LF)
                    begin
                        if (state.phase == PH_LINE)
                        begin
                            state_next.phase           = PH_LEAD;
                            state_next.comment_escaped = 1'b0;
                            state_next.comment_star    = 1'b0;
                            state_next.slash_seen      = 1'b0;
                        end
                    end
                    else if (in_byte == CH_STAR)
                    begin
                        state_next.comment_escaped = 1'b0;
                        state_next.comment_star    = 1'b1;
                    end
                    else if (in_byte == CH_BSLASH)
                        state_next.comment_escaped = !state.comment_escaped;
                    else
                    begin
                        state_next.comment_escaped = 1'b0;
                        state_next.comment_star    = 1'b0;
                    end
                end
                PH_KEY:
                begin
                    state_next.keyword_matches  = match_next;
                    state_next.keyword_position = pos_next;
                    if (pos_next >= KEY_LEN)
                    begin
                        if (match_next)
                        begin
                            state_next.phase          = PH_NAME;
                            state_next.name_length    = '0;
                            state_next.name_truncated = 1'b0;
                        end
                        else
                        begin
                            result = '{valid: 1'b1, kind: KIND_FINISH, name_char: 8'd0,
                                       status: ST_NOT_PKG};
                            state_next.phase = PH_DONE;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (in_byte == CH_SEMI)
                    begin
                        result = '{valid: 1'b1, kind: KIND_FINISH, name_char: 8'd0,
                                   status: state.name_truncated ? ST_TRUNC : ST_FOUND};
                        state_next.phase = PH_DONE;
                    end
                    else if (in_byte == CH_DOT || is_alnum)
                    begin
                        if (name_full)
                            state_next.name_truncated = 1'b1;
                        else
                        begin
                            state_next.name_length = state.name_length + LEN_W'(1);
                            result = '{valid: 1'b1, kind: KIND_CHAR,
                                       name_char: (in_byte == CH_DOT) ? CH_SLASH : in_byte,
                                       status: ST_FOUND};
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

endmodule

>>> sv/java_source_package_name_scanner_core.sv
// path: an accepted item passes the input register, then the scan update into the
//   result register, from which it leaves when out_stall is low; items with no result
//   vanish
// throughput: one item per cycle, limited only by out_stall back-pressure
// reset: rst_n clears the valid flags and returns the scanner to the leading scan,
//   ready for a fresh text with no name characters counted
module java_source_package_name_scanner_core #(
    parameter int unsigned MAX_NAME = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] name_char,
    output logic [1:0] status
);
    import jpns_pkg::*;

    // input register: one item waiting for the scan update
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;

    // scanner state, updated once per item
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_result_t res;

    // result register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  name_char_reg;
    logic [1:0]  status_reg;

    logic        advance;

    // the held item moves on when the result register is free or drains this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    // the input register refills whenever its item moves on or it is empty
    assign in_stall = in_valid_reg && !advance;

    jpns_step #(
        .MAX_NAME(MAX_NAME)
    ) u_step (
        .state      (state_reg),
        .in_byte    (byte_reg),
        .end_of_text(eot_reg),
        .state_next (state_next),
        .result     (res)
    );

    // control: valid flags and scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res.valid;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
            eot_reg  <= end_of_text;
        end
        if (advance && res.valid)
        begin
            kind_reg      <= res.kind;
            name_char_reg <= res.name_char;
            status_reg    <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign name_char = name_char_reg;
    assign status    = status_reg;

    // an end item always re-arms the scanner
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && eot_reg |=> state_reg.phase == PH_LEAD)
        else $error("scanner not re-armed after end item");

    // the emitted name never exceeds the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.name_length <= LEN_W'(MAX_NAME))
        else $error("name length beyond limit");

    // a finish record leaves the scanner finished or re-armed
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid && res.kind == KIND_FINISH
        |=> state_reg.phase == PH_DONE || state_reg.phase == PH_LEAD)
        else $error("finish record without finishing");

    // name characters come only from the name phase
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid && res.kind == KIND_CHAR |-> state_reg.phase == PH_NAME)
        else $error("name character outside name phase");

    // a held result stays put while out_stall holds it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(kind_reg)
        && $stable(name_char_reg) && $stable(status_reg))
        else $error("held result changed");

endmodule

>>> tb/java_source_package_name_scanner_core_test.sv
`timescale 1ns / 1ps

module java_source_package_name_scanner_core_test;
    import jpns_pkg::*;

    // run shape
    localparam int NAME_LIMIT   = 128;
    localparam int ITEM_GOAL    = 550;
    localparam int QUIET_AFTER  = 470;   // no idling on either side past this many items
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off, long enough to fill the block
    localparam int DRAIN_CYCLES = 12;    // idle time after the last expected result before the end
    localparam int REPORT_MAX   = 10;

    // keyword tail after the leading 'p', first letter in the top byte
    localparam logic [47:0] TAIL_TEXT = "ackage";

    // one result item of the scanner
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [1:0] st;
    } name_item_t;

    // one row of the directed table; fixed rows carry a hand-typed expectation
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       fixed;
        logic       has_out;
        name_item_t out;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] name_char;
    logic [1:0] status;

    java_source_package_name_scanner_core #(
        .MAX_NAME(NAME_LIMIT)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .end_of_text(end_of_text),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .name_char  (name_char),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shared between the feeding side, the draining side and the checker
    name_item_t  expected_q[$];
    plan_row_t   plan[$];
    logic [7:0]  text_q[$];
    int          fail_count = 0;
    int          fed_items  = 0;
    bit          quiet      = 1'b0;
    bit          hold_req   = 1'b0;

    // scanner state as predicted from the accepted items
    phase_t      scan_stage;
    logic        after_slash;
    logic        esc_open;
    logic        star_prev;
    logic [2:0]  key_idx;
    logic        key_ok;
    logic [7:0]  emitted;
    logic        dropped;

    task automatic scan_rearm();
        scan_stage  = PH_LEAD;
        after_slash = 1'b0;
        esc_open    = 1'b0;
        star_prev   = 1'b0;
        key_idx     = 3'd0;
        key_ok      = 1'b1;
        emitted     = 8'd0;
        dropped     = 1'b0;
    endtask

    task automatic emit_finish(input logic [1:0] st, output logic got, output name_item_t r);
        got        = 1'b1;
        r          = {KIND_FINISH, 8'h00, st};
        scan_stage = PH_DONE;
    endtask

    // past the limit the character is dropped and the finish turns into truncated
    task automatic emit_char(input logic [7:0] c, output logic got, output name_item_t r);
        r = '0;
        if (emitted >= NAME_LIMIT)
        begin
            dropped = 1'b1;
            got     = 1'b0;
        end
        else
        begin
            emitted = emitted + 8'd1;
            got     = 1'b1;
            r       = {KIND_CHAR, c, ST_FOUND};
        end
    endtask

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_OFS) : c;
    endfunction

    // advance the predicted scanner by one accepted item
    task automatic scan_step(input logic [7:0] c, input logic eot,
                             output logic got, output name_item_t r);
        logic [2:0] pos;
        logic       close_now;
        got = 1'b0;
        r   = '0;
        if (eot)
        begin
            // end item: finish unless already finished, then back to the leading scan
            if (scan_stage == PH_NAME)
                emit_finish(dropped ? ST_TRUNC : ST_FOUND, got, r);
            else if (scan_stage <= PH_KEY)
                emit_finish(ST_EARLY_END, got, r);
            scan_rearm();
        end
        else
        begin
            case (scan_stage)
                PH_LEAD:
                begin
                    if (c == CH_SLASH)
                    begin
                        if (after_slash)
                        begin
                            scan_stage  = PH_LINE;
                            esc_open    = 1'b0;
                            star_prev   = 1'b0;
                            after_slash = 1'b0;
                        end
                        else
                            after_slash = 1'b1;
                    end
                    else if (c == CH_STAR)
                    begin
                        if (after_slash)
                        begin
                            scan_stage = PH_BLOCK;
                            esc_open   = 1'b0;
                            star_prev  = 1'b0;
                        end
                        after_slash = 1'b0;
                    end
                    else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
                        after_slash = 1'b0;
                    else
                    begin
                        after_slash = 1'b0;
                        if (c == CH_LOW_P)
                        begin
                            scan_stage = PH_KEY;
                            key_idx    = 3'd0;
                            key_ok     = 1'b1;
                        end
                        else
                            emit_finish(ST_NOT_PKG, got, r);
                    end
                end
                PH_LINE, PH_BLOCK:
                begin
                    close_now = 1'b0;
                    if (c == CH_SLASH)
                        close_now = star_prev && !esc_open;
                    else if (c == CH_LF)
                        close_now = (scan_stage == PH_LINE);
                    else if (c == CH_STAR)
                    begin
                        esc_open  = 1'b0;
                        star_prev = 1'b1;
                    end
                    else if (c == CH_BSLASH)
                        esc_open = !esc_open;
                    else
                    begin
                        esc_open  = 1'b0;
                        star_prev = 1'b0;
                    end
                    if (close_now)
                    begin
                        scan_stage  = PH_LEAD;
                        esc_open    = 1'b0;
                        star_prev   = 1'b0;
                        after_slash = 1'b0;
                    end
                end
                PH_KEY:
                begin
                    // all six bytes are read even after a mismatch
                    pos = (key_idx > 3'd5) ? 3'd5 : key_idx;
                    if (lower_of(c) != TAIL_TEXT[8 * (5 - pos) +: 8])
                        key_ok = 1'b0;
                    key_idx = pos + 3'd1;
                    if (key_idx >= 3'd6)
                    begin
                        if (key_ok)
                        begin
                            scan_stage = PH_NAME;
                            emitted    = 8'd0;
                            dropped    = 1'b0;
                        end
                        else
                            emit_finish(ST_NOT_PKG, got, r);
                    end
                end
                PH_NAME:
                begin
                    if (c == CH_SEMI)
                        emit_finish(dropped ? ST_TRUNC : ST_FOUND, got, r);
                    else if (c == CH_DOT)
                        emit_char(CH_SLASH, got, r);
                    else if ((c >= CH_0 && c <= CH_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                             (c >= CH_LOW_A && c <= CH_LOW_Z))
                        emit_char(c, got, r);
                end
                default:
                begin
                    // finished: bytes ignored until the end item
                end
            endcase
        end
    endtask

    // offer one item, wait for its acceptance, then record what it should cause
    task automatic send_item(input logic [7:0] b, input logic eot, input logic fixed,
                             input logic has_out, input name_item_t out);
        int         gap;
        logic       got;
        name_item_t r;
        phase_t     was;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        was = scan_stage;
        scan_step(b, eot, got, r);
        if (fixed)
        begin
            if (has_out)
                expected_q.push_back(out);
        end
        else if (got)
            expected_q.push_back(r);
        // bytes after a finish are merely skipped and do not count
        if (was != PH_DONE)
            fed_items++;
    endtask

    task automatic add_row(input logic [7:0] b, input logic eot, input logic fixed,
                           input logic has_out, input name_item_t out);
        plan.push_back({b, eot, fixed, has_out, out});
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] random_name_char();
        case ($urandom_range(0, 3))
            0:       return CH_LOW_A + 8'($urandom_range(0, 25));
            1:       return CH_UP_A + 8'($urandom_range(0, 25));
            2:       return CH_0 + 8'($urandom_range(0, 9));
            default: return CH_DOT;
        endcase
    endfunction

    // comment text with stars, backslashes and now and then a stray byte
    task automatic add_comment_body();
        int n;
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0:       text_q.push_back(CH_LOW_A);
                1:       text_q.push_back(CH_STAR);
                2:       text_q.push_back(CH_BSLASH);
                3:       text_q.push_back(CH_SPACE);
                4:       text_q.push_back(CH_BSLASH);
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // one source text: mostly a well formed package statement with random content
    task automatic build_text(input int idx);
        int         flavor;
        int         bad;
        int         len;
        int         cut;
        int         n;
        logic [7:0] c;
        text_q.delete();
        flavor = $urandom_range(0, 19);
        if (flavor == 0)
        begin
            // plain noise
            n = $urandom_range(1, 6);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (flavor != 1)
        begin
            // leading blanks and comments
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 4))
                    0: text_q.push_back(random_blank());
                    1:
                    begin
                        text_q.push_back(CH_SLASH);
                        text_q.push_back(CH_SLASH);
                        add_comment_body();
                        text_q.push_back(CH_LF);
                    end
                    2:
                    begin
                        text_q.push_back(CH_SLASH);
                        text_q.push_back(CH_STAR);
                        add_comment_body();
                        text_q.push_back(CH_STAR);
                        text_q.push_back(CH_SLASH);
                    end
                    3:
                    begin
                        // lone slash
                        text_q.push_back(CH_SLASH);
                        text_q.push_back(CH_SPACE);
                    end
                    default: text_q.push_back(CH_SPACE);
                endcase
            end
            // keyword, random case in the tail, sometimes spoiled
            if ($urandom_range(0, 11) == 0)
                text_q.push_back(8'($urandom_range(0, 255)));
            else
                text_q.push_back(CH_LOW_P);
            bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 6;
            for (int k = 0; k < 6; k++)
            begin
                c = TAIL_TEXT[8 * (5 - k) +: 8];
                if (k == bad)
                    c = 8'($urandom_range(0, 255));
                else if ($urandom_range(0, 1) == 1)
                    c = c ^ CASE_OFS;
                text_q.push_back(c);
            end
            // name: mostly short, a few around the length limit
            if (idx == 1)
                len = NAME_LIMIT + 3;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(NAME_LIMIT - 4, NAME_LIMIT + 6);
            else
                len = $urandom_range(0, 12);
            for (int k = 0; k < len; k++)
            begin
                text_q.push_back(random_name_char());
                if (len < 20 && $urandom_range(0, 7) == 0)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) != 0)
                text_q.push_back(CH_SEMI);
            // bytes after the finish
            n = $urandom_range(0, 2);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
            // sometimes the text stops early, at a random point, maybe inside a comment or the keyword
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(0, text_q.size());
                while (text_q.size() > cut)
                    void'(text_q.pop_back());
            end
        end
    endtask

    // feeding side: reset, directed table, then random texts
    initial
    begin
        int text_idx;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_byte     <= 8'h00;
        end_of_text <= 1'b0;
        scan_rearm();

        // empty text right after reset ends early
        add_row(8'h00, 1'b1, 1'b1, 1'b1, {KIND_FINISH, 8'h00, ST_EARLY_END});
        // top byte value is not a package statement
        add_row(8'hff, 1'b0, 1'b1, 1'b1, {KIND_FINISH, 8'h00, ST_NOT_PKG});
        // bytes after a finish are ignored, and the end item yields nothing
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
        // blanks
        add_row(CH_SPACE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_LF, 1'b0, 1'b0, 1'b0, '0);
        // line comment closed by a line feed
        add_row(CH_SLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_LF, 1'b0, 1'b0, 1'b0, '0);
        // block comment, an escaped star-slash does not close it
        add_row(CH_SLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_STAR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_STAR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_STAR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, 1'b0, '0);
        // keyword in mixed case
        add_row(CH_LOW_P, 1'b0, 1'b0, 1'b0, '0);
        add_row("A", 1'b0, 1'b0, 1'b0, '0);
        add_row("c", 1'b0, 1'b0, 1'b0, '0);
        add_row("K", 1'b0, 1'b0, 1'b0, '0);
        add_row("a", 1'b0, 1'b0, 1'b0, '0);
        add_row("G", 1'b0, 1'b0, 1'b0, '0);
        add_row("e", 1'b0, 1'b0, 1'b0, '0);
        // name: dot turns into slash, zero byte skipped, semicolon finishes
        add_row(CH_DOT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_9, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(CH_SEMI, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].b, plan[i].eot, plan[i].fixed, plan[i].has_out, plan[i].out);

        fed_items = 0;
        text_idx  = 0;
        while (fed_items < ITEM_GOAL)
        begin
            // long hold-off on the receiver during the long name, so the block backs up
            if (text_idx == 1)
                hold_req = 1'b1;
            build_text(text_idx);
            foreach (text_q[k])
                send_item(text_q[k], 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
            if (text_idx == 4)
            begin
                // sender pause until the block has delivered everything
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            text_idx++;
            if (fed_items >= QUIET_AFTER)
                quiet = 1'b1;
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // draining side: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        int hold_cnt;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                n = $urandom_range(1, 6);
                out_stall <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        name_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                    $display("unexpected result: kind %0d char %02h status %0d",
                             kind, name_char, status);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (kind !== want.kind || name_char !== want.ch || status !== want.st)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("result mismatch: expected kind %0d char %02h status %0d, %s",
                                 want.kind, want.ch, want.st,
                                 $sformatf("got kind %0d char %02h status %0d",
                                           kind, name_char, status));
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
